>>> rtl/sba_pkg.sv
package sba_pkg;

	// Default sizes of the frame store and of the magnification.
	localparam int FB_SIDE_DEF   = 256;
	localparam int MAX_SCALE_DEF = 16;

	// Byte address width of the configuration port.
	localparam int APB_AW = 5;

	// Command codes.
	localparam logic [1:0] CMD_BLIT  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Blit mode codes.
	localparam logic [1:0] MODE_BLEND  = 2'd0;
	localparam logic [1:0] MODE_MUL    = 2'd1;
	localparam logic [1:0] MODE_SCALE  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_FB_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FB_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X  = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
	localparam logic [2:0] REG_BLIT_MODE = 3'd4;
	localparam logic [2:0] REG_ALPHA_MUL = 3'd5;
	localparam logic [2:0] REG_SCALE     = 3'd6;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	// One command transaction.
	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] pixel;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
	} cmd_t;

	// One response transaction.
	typedef struct packed {
		logic [31:0] read_data;
		logic [16:0] pixels_written;
	} rsp_t;

	// Floor of x / 255, exact for every 16-bit x below 255 * 256.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

>>> rtl/sprite_blit_alpha_blend_top.sv
// Sprite blitter over an RGBA8888 frame store of FB_SIDE x FB_SIDE words held in one
// synchronous RAM with one write and one read port. Commands are handled one at a time:
// a read forms the address and reads the RAM, an opaque copy writes once the address is
// formed, an alpha blend steps through address, RAM read, channel products, divide and
// write back, a clear fills the used area at one word per cycle, and a scaled copy walks
// the block row by row, forming each row address first and then writing each cell of the
// row that lies inside the used area. The response sits in an output register, so the next
// command is taken while it waits. After reset the block sweeps the whole RAM to zero and
// takes no command until then; configuration writes are taken at any time.
module sprite_blit_alpha_blend_top #(
	parameter int FB_SIDE   = sba_pkg::FB_SIDE_DEF,
	parameter int MAX_SCALE = sba_pkg::MAX_SCALE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sba_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  sba_pkg::cmd_t             cmd,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output sba_pkg::rsp_t             rsp
);

	localparam int DEPTH   = FB_SIDE * FB_SIDE;
	localparam int AW      = $clog2(DEPTH);
	localparam int DIM_W   = $clog2(FB_SIDE + 1);
	localparam int SC_W    = $clog2(MAX_SCALE + 1);
	localparam int OFF_W   = 8 + SC_W;
	localparam int COORD_W = 17 + SC_W;
	localparam int CW      = $clog2(MAX_SCALE * MAX_SCALE + 1);

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_ADDR = 4'd2;
	localparam logic [3:0] ST_MOD  = 4'd3;
	localparam logic [3:0] ST_WR   = 4'd4;
	localparam logic [3:0] ST_CLR  = 4'd5;
	localparam logic [3:0] ST_ROW  = 4'd6;
	localparam logic [3:0] ST_COL  = 4'd7;
	localparam logic [3:0] ST_RESP = 4'd8;

	// Configuration registers.
	logic [8:0]         fb_width_q;
	logic [8:0]         fb_height_q;
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [1:0]         blit_mode_q;
	logic [7:0]         alpha_mul_q;
	logic [4:0]         scale_q;

	// Sequencer and per-command state.
	logic [3:0]                state_q;
	logic [AW-1:0]             sweep_q;
	logic [AW:0]               n_q;
	logic [1:0]                cmd_q;
	logic [31:0]               pixel_q;
	logic [1:0]                mode_q;
	logic [7:0]                alpha_q;
	logic [SC_W-1:0]           sc_q;
	logic [SC_W-1:0]           sx_q;
	logic [SC_W-1:0]           sy_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [AW-1:0]             addr_q;
	logic                      row_ok_q;
	logic [AW-1:0]             row_base_q;
	logic [CW-1:0]             cnt_q;
	logic [15:0]               sum_q [4];
	sba_pkg::rsp_t             res_q;
	sba_pkg::rsp_t             rsp_q;
	logic                      rsp_valid_q;

	// Derived values.
	logic [DIM_W-1:0]          eff_w;
	logic [DIM_W-1:0]          eff_h;
	logic [SC_W-1:0]           sc_cfg;
	logic [1:0]                mode_cfg;
	logic [OFF_W-1:0]          px_ext;
	logic [OFF_W-1:0]          py_ext;
	logic [OFF_W-1:0]          off_x;
	logic [OFF_W-1:0]          off_y;
	logic [15:0]               amul;
	logic [7:0]                alpha_in;
	logic signed [COORD_W-1:0] cx_in;
	logic signed [COORD_W-1:0] cy_in;
	logic [2*DIM_W-1:0]        pt_prod;
	logic [2*DIM_W-1:0]        area_prod;
	logic [2*DIM_W-1:0]        row_prod;
	logic [AW-1:0]             idx;
	logic [AW:0]               n_now;
	logic                      pt_ok;
	logic signed [COORD_W-1:0] tx;
	logic signed [COORD_W-1:0] ty;
	logic                      tx_ok;
	logic                      ty_ok;
	logic                      col_wr;
	logic [CW-1:0]             cnt_next;
	logic [7:0]                inv;
	logic [31:0]               blended;
	logic                      rsp_free;
	logic                      rsp_load;
	logic                      fin;
	sba_pkg::rsp_t             fin_rsp;

	// Frame store port signals.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [31:0]   mem_rdata;

	sba_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(idx),
		.rdata(mem_rdata)
	);

	assign pready    = 1'b1;
	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_load  = rsp_free && (fin || state_q == ST_RESP);

	// Configuration read mux.
	always_comb begin
		unique case (paddr[4:2])
			sba_pkg::REG_FB_WIDTH:  prdata = 32'(fb_width_q);
			sba_pkg::REG_FB_HEIGHT: prdata = 32'(fb_height_q);
			sba_pkg::REG_ORIGIN_X:  prdata = {16'b0, origin_x_q};
			sba_pkg::REG_ORIGIN_Y:  prdata = {16'b0, origin_y_q};
			sba_pkg::REG_BLIT_MODE: prdata = 32'(blit_mode_q);
			sba_pkg::REG_ALPHA_MUL: prdata = 32'(alpha_mul_q);
			sba_pkg::REG_SCALE:     prdata = 32'(scale_q);
			default:                prdata = 32'b0;
		endcase
	end

	// Effective sizes, scale and mode from the configuration.
	always_comb begin
		eff_w  = (32'(fb_width_q) > 32'(FB_SIDE)) ? DIM_W'(FB_SIDE) : DIM_W'(fb_width_q);
		eff_h  = (32'(fb_height_q) > 32'(FB_SIDE)) ? DIM_W'(FB_SIDE) : DIM_W'(fb_height_q);
		sc_cfg = (32'(scale_q) > 32'(MAX_SCALE)) ? SC_W'(MAX_SCALE) : SC_W'(scale_q);
		mode_cfg = blit_mode_q;
		if (blit_mode_q == sba_pkg::MODE_UNUSED) begin
			mode_cfg = sba_pkg::MODE_BLEND;
		end
		if (blit_mode_q == sba_pkg::MODE_SCALE && sc_cfg == SC_W'(1)) begin
			mode_cfg = sba_pkg::MODE_BLEND;
		end
	end

	// Target coordinates and effective alpha of an incoming command.
	always_comb begin
		px_ext = OFF_W'(cmd.pos_x);
		py_ext = OFF_W'(cmd.pos_y);
		if (mode_cfg == sba_pkg::MODE_SCALE) begin
			off_x = px_ext * OFF_W'(sc_cfg);
			off_y = py_ext * OFF_W'(sc_cfg);
		end else begin
			off_x = px_ext;
			off_y = py_ext;
		end
		if (cmd.command == sba_pkg::CMD_READ) begin
			cx_in = $signed(COORD_W'(px_ext));
			cy_in = $signed(COORD_W'(py_ext));
		end else begin
			cx_in = COORD_W'(origin_x_q) + $signed(COORD_W'(off_x));
			cy_in = COORD_W'(origin_y_q) + $signed(COORD_W'(off_y));
		end
		amul = 16'(cmd.pixel[7:0]) * 16'(alpha_mul_q);
		if (mode_cfg == sba_pkg::MODE_MUL) begin
			alpha_in = sba_pkg::div255(amul);
		end else begin
			alpha_in = cmd.pixel[7:0];
		end
	end

	// Single-word address, clip check and used area.
	always_comb begin
		pt_prod   = (2*DIM_W)'(cy_q[DIM_W-1:0]) * (2*DIM_W)'(eff_w);
		idx       = AW'(pt_prod) + AW'(cx_q[DIM_W-1:0]);
		pt_ok     = !cx_q[COORD_W-1] && (cx_q[COORD_W-2:0] < (COORD_W-1)'(eff_w))
		         && !cy_q[COORD_W-1] && (cy_q[COORD_W-2:0] < (COORD_W-1)'(eff_h));
		area_prod = (2*DIM_W)'(eff_w) * (2*DIM_W)'(eff_h);
		n_now     = (AW+1)'(area_prod);
	end

	// Scaled block walk: row address and column clip.
	always_comb begin
		ty       = cy_q + $signed(COORD_W'(sy_q));
		ty_ok    = !ty[COORD_W-1] && (ty[COORD_W-2:0] < (COORD_W-1)'(eff_h));
		row_prod = (2*DIM_W)'(ty[DIM_W-1:0]) * (2*DIM_W)'(eff_w);
		tx       = cx_q + $signed(COORD_W'(sx_q));
		tx_ok    = !tx[COORD_W-1] && (tx[COORD_W-2:0] < (COORD_W-1)'(eff_w));
		col_wr   = row_ok_q && tx_ok;
		cnt_next = cnt_q + CW'(col_wr);
	end

	// Final divide of the blend: colors from the sums, alpha on top of the source alpha.
	always_comb begin
		inv = sba_pkg::ALPHA_OPAQUE - alpha_q;
		for (int k = 0; k < 4; k++) begin
			if (k == 0) begin
				blended[8*k +: 8] = alpha_q + sba_pkg::div255(sum_q[k]);
			end else begin
				blended[8*k +: 8] = sba_pkg::div255(sum_q[k]);
			end
		end
	end

	// Frame store writes and command completion.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = pixel_q;
		fin       = 1'b0;
		fin_rsp   = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = 32'b0;
			end
			ST_ADDR: begin
				case (cmd_q)
					sba_pkg::CMD_CLEAR: begin
						fin = (n_now == '0);
					end
					sba_pkg::CMD_READ: begin
						fin = !pt_ok;
					end
					sba_pkg::CMD_BLIT: begin
						if (mode_q == sba_pkg::MODE_SCALE) begin
							fin = (sc_q == '0) || (alpha_q == 8'd0);
						end else if (!pt_ok || alpha_q == 8'd0) begin
							fin = 1'b1;
						end else if (mode_q == sba_pkg::MODE_BLEND
						          && alpha_q == sba_pkg::ALPHA_OPAQUE) begin
							mem_we    = 1'b1;
							mem_waddr = idx;
							fin       = 1'b1;
							fin_rsp.pixels_written = 17'd1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_MOD: begin
				if (cmd_q == sba_pkg::CMD_READ) begin
					fin               = 1'b1;
					fin_rsp.read_data = mem_rdata;
				end
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_wdata = blended;
				fin       = 1'b1;
				fin_rsp.pixels_written = 17'd1;
			end
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				if ({1'b0, sweep_q} == n_q - (AW+1)'(1)) begin
					fin = 1'b1;
					fin_rsp.pixels_written = 17'(n_q);
				end
			end
			ST_COL: begin
				mem_we    = col_wr;
				mem_waddr = row_base_q + AW'(tx[DIM_W-1:0]);
				if (sx_q == sc_q - SC_W'(1) && sy_q == sc_q - SC_W'(1)) begin
					fin = 1'b1;
					fin_rsp.pixels_written = 17'(cnt_next);
				end
			end
			default: begin
			end
		endcase
	end

	// Blend products and sums, one lane per byte.
	always_ff @(posedge clk) begin
		if (state_q == ST_MOD) begin
			for (int k = 0; k < 4; k++) begin
				if (k == 0) begin
					sum_q[k] <= 16'(mem_rdata[8*k +: 8]) * 16'(inv);
				end else begin
					sum_q[k] <= 16'(pixel_q[8*k +: 8]) * 16'(alpha_q)
					          + 16'(mem_rdata[8*k +: 8]) * 16'(inv);
				end
			end
		end
	end

	// Configuration, sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q  <= 9'd256;
			fb_height_q <= 9'd256;
			origin_x_q  <= 16'sd0;
			origin_y_q  <= 16'sd0;
			blit_mode_q <= sba_pkg::MODE_BLEND;
			alpha_mul_q <= 8'd255;
			scale_q     <= 5'd1;
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Register writes complete in the access phase.
			if (psel && penable && pwrite) begin
				unique case (paddr[4:2])
					sba_pkg::REG_FB_WIDTH:  fb_width_q  <= pwdata[8:0];
					sba_pkg::REG_FB_HEIGHT: fb_height_q <= pwdata[8:0];
					sba_pkg::REG_ORIGIN_X:  origin_x_q  <= pwdata[15:0];
					sba_pkg::REG_ORIGIN_Y:  origin_y_q  <= pwdata[15:0];
					sba_pkg::REG_BLIT_MODE: blit_mode_q <= pwdata[1:0];
					sba_pkg::REG_ALPHA_MUL: alpha_mul_q <= pwdata[7:0];
					sba_pkg::REG_SCALE:     scale_q     <= pwdata[4:0];
					default: begin
					end
				endcase
			end

			// The output register takes a finished or a waiting response when it is free.
			if (rsp_load) begin
				rsp_q       <= (state_q == ST_RESP) ? res_q : fin_rsp;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// A finished command returns to idle, or waits for the output register.
			if (fin) begin
				if (rsp_free) begin
					state_q <= ST_IDLE;
				end else begin
					res_q   <= fin_rsp;
					state_q <= ST_RESP;
				end
			end else begin
				unique case (state_q)
					ST_INIT: begin
						sweep_q <= sweep_q + AW'(1);
						if (sweep_q == AW'(DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (cmd_valid) begin
							cmd_q   <= cmd.command;
							pixel_q <= cmd.pixel;
							mode_q  <= mode_cfg;
							sc_q    <= sc_cfg;
							alpha_q <= alpha_in;
							cx_q    <= cx_in;
							cy_q    <= cy_in;
							state_q <= ST_ADDR;
						end
					end
					ST_ADDR: begin
						addr_q <= idx;
						sx_q   <= '0;
						sy_q   <= '0;
						cnt_q  <= '0;
						n_q    <= n_now;
						sweep_q <= '0;
						if (cmd_q == sba_pkg::CMD_CLEAR) begin
							state_q <= ST_CLR;
						end else if (cmd_q == sba_pkg::CMD_BLIT
						          && mode_q == sba_pkg::MODE_SCALE) begin
							state_q <= ST_ROW;
						end else begin
							state_q <= ST_MOD;
						end
					end
					ST_MOD: begin
						state_q <= ST_WR;
					end
					ST_WR: begin
						state_q <= ST_IDLE;
					end
					ST_CLR: begin
						sweep_q <= sweep_q + AW'(1);
					end
					ST_ROW: begin
						row_ok_q   <= ty_ok;
						row_base_q <= AW'(row_prod);
						state_q    <= ST_COL;
					end
					ST_COL: begin
						cnt_q <= cnt_next;
						if (sx_q == sc_q - SC_W'(1)) begin
							sx_q    <= '0;
							sy_q    <= sy_q + SC_W'(1);
							state_q <= ST_ROW;
						end else begin
							sx_q <= sx_q + SC_W'(1);
						end
					end
					ST_RESP: begin
						if (rsp_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/sba_ram.sv
module sba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> tb/sv/blit_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both command channels, keeps a shadow copy of
// the frame store and the settings, and compares every response transaction with
// the oldest predicted one.
module blit_checker
	import sba_pkg::*;
#(
	parameter int FB_SIDE   = FB_SIDE_DEF,
	parameter int MAX_SCALE = MAX_SCALE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              cmd_valid,
	input  logic              cmd_ready,
	input  cmd_t              cmd,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  rsp_t              rsp,
	output int                fail_count,
	output int                pending
);

	// Shadow frame store and settings.
	logic [31:0]        shadow_fb [0:FB_SIDE*FB_SIDE-1];
	logic [8:0]         cfg_width;
	logic [8:0]         cfg_height;
	logic signed [15:0] cfg_org_x;
	logic signed [15:0] cfg_org_y;
	logic [1:0]         cfg_mode;
	logic [7:0]         cfg_amul;
	logic [4:0]         cfg_scale;

	rsp_t awaited_rsp [$];
	int   errors;

	function automatic int used_w();
		return (int'(cfg_width) > FB_SIDE) ? FB_SIDE : int'(cfg_width);
	endfunction

	function automatic int used_h();
		return (int'(cfg_height) > FB_SIDE) ? FB_SIDE : int'(cfg_height);
	endfunction

	// Linear word index of a framebuffer position, or -1 when it is outside the used area.
	function automatic int cell_index(int tx, int ty);
		int w;
		int h;
		w = used_w();
		h = used_h();
		if (tx < 0 || ty < 0 || tx >= w || ty >= h) return -1;
		return ty * w + tx;
	endfunction

	// Straight-alpha over operator with floor division by 255.
	function automatic logic [31:0] mix_over(logic [31:0] src, int a, logic [31:0] dst);
		logic [31:0] res;
		int          inv;
		inv = 255 - a;
		for (int k = 1; k < 4; k++) begin
			res[8*k +: 8] = 8'((int'(src[8*k +: 8]) * a + int'(dst[8*k +: 8]) * inv) / 255);
		end
		res[7:0] = 8'(a + int'(dst[7:0]) * inv / 255);
		return res;
	endfunction

	// Applies one command to the shadow state and returns the response it should give.
	function automatic rsp_t apply_command(cmd_t c);
		rsp_t       r;
		logic [1:0] mode;
		int         sc;
		int         a;
		int         idx;
		int         cnt;
		int         w;
		int         h;
		r = '0;
		w = used_w();
		h = used_h();
		case (c.command)
			CMD_BLIT: begin
				mode = (cfg_mode == MODE_UNUSED) ? MODE_BLEND : cfg_mode;
				sc = (int'(cfg_scale) > MAX_SCALE) ? MAX_SCALE : int'(cfg_scale);
				a = int'(c.pixel[7:0]);
				if (mode == MODE_SCALE && sc == 1) mode = MODE_BLEND;
				if (mode == MODE_SCALE) begin
					// Opaque block copy, clipped cell by cell.
					cnt = 0;
					if (sc != 0 && a != 0) begin
						for (int sy = 0; sy < sc; sy++) begin
							for (int sx = 0; sx < sc; sx++) begin
								idx = cell_index(int'(cfg_org_x) + int'(c.pos_x) * sc + sx,
									int'(cfg_org_y) + int'(c.pos_y) * sc + sy);
								if (idx >= 0) begin
									shadow_fb[idx] = c.pixel;
									cnt++;
								end
							end
						end
					end
					r.pixels_written = 17'(cnt);
				end else begin
					idx = cell_index(int'(cfg_org_x) + int'(c.pos_x),
						int'(cfg_org_y) + int'(c.pos_y));
					if (idx >= 0) begin
						if (mode == MODE_MUL) a = a * int'(cfg_amul) / 255;
						if (a != 0) begin
							if (mode != MODE_MUL && a == 255) shadow_fb[idx] = c.pixel;
							else shadow_fb[idx] = mix_over(c.pixel, a, shadow_fb[idx]);
							r.pixels_written = 17'd1;
						end
					end
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < w * h; i++) shadow_fb[i] = c.pixel;
				r.pixels_written = 17'(w * h);
			end
			CMD_READ: begin
				idx = cell_index(int'(c.pos_x), int'(c.pos_y));
				if (idx >= 0) r.read_data = shadow_fb[idx];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < FB_SIDE * FB_SIDE; i++) shadow_fb[i] = '0;
			cfg_width  = 9'd256;
			cfg_height = 9'd256;
			cfg_org_x  = '0;
			cfg_org_y  = '0;
			cfg_mode   = MODE_BLEND;
			cfg_amul   = 8'd255;
			cfg_scale  = 5'd1;
			awaited_rsp.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Register writes on the configuration port.
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_FB_WIDTH:  cfg_width  = pwdata[8:0];
					REG_FB_HEIGHT: cfg_height = pwdata[8:0];
					REG_ORIGIN_X:  cfg_org_x  = pwdata[15:0];
					REG_ORIGIN_Y:  cfg_org_y  = pwdata[15:0];
					REG_BLIT_MODE: cfg_mode   = pwdata[1:0];
					REG_ALPHA_MUL: cfg_amul   = pwdata[7:0];
					REG_SCALE:     cfg_scale  = pwdata[4:0];
					default: begin
					end
				endcase
			end

			// Predict the response of each accepted command transaction.
			if (cmd_valid && cmd_ready) awaited_rsp.push_back(apply_command(cmd));

			// Compare each accepted response transaction with the oldest prediction.
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					if (errors < 10) begin
						$display("%t: response with none outstanding: read_data %08h pixels_written %0d",
							$realtime, rsp.read_data, rsp.pixels_written);
					end
					errors++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.read_data !== want.read_data ||
						rsp.pixels_written !== want.pixels_written) begin
						if (errors < 10) begin
							$display("%t: response mismatch: read_data exp %08h got %08h, pixels_written exp %0d got %0d",
								$realtime, want.read_data, rsp.read_data,
								want.pixels_written, rsp.pixels_written);
						end
						errors++;
					end
				end
			end
			fail_count <= errors;
			pending <= awaited_rsp.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sba_pkg::*;

	localparam int         CYCLE_LIMIT = 10000000;
	localparam logic [1:0] CMD_SPARE   = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	cmd_t               cmd = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	int                 fail_count;
	int                 pending;
	bit                 calm_phase = 1'b0;
	int                 ready_hold = 0;
	int                 cycles = 0;

	sprite_blit_alpha_blend_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	blit_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sprite_blit_alpha_blend_top verification failed");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_gap();
		int r;
		if (calm_phase) return 0;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 17) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	// Response side stalls at random.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			rsp_ready <= 1'b0;
		end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
			ready_hold <= idle_gap();
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic cmd_t mk_cmd(logic [1:0] op, logic [31:0] pix, logic [7:0] x, logic [7:0] y);
		cmd_t c;
		c.command = op;
		c.pixel = pix;
		c.pos_x = x;
		c.pos_y = y;
		return c;
	endfunction

	// Framebuffer dimension, mostly small so that clears stay cheap.
	function automatic int pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13) return $urandom_range(1, 24);
		if (r < 16) return $urandom_range(25, 256);
		if (r == 16) return 0;
		if (r == 17) return 1;
		return $urandom_range(257, 511);
	endfunction

	function automatic int pick_origin();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return int'($urandom_range(0, 12)) - 6;
		if (r == 7) return -int'($urandom_range(0, 300));
		if (r == 8) return ($urandom_range(0, 1) == 0) ? -32768 : 32767;
		return int'($signed(16'($urandom())));
	endfunction

	// Position near the used area, with an occasional value anywhere in the field.
	function automatic logic [7:0] near_pos(int base, int span);
		int p;
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		p = base + int'($urandom_range(0, span));
		return (p > 255) ? 8'd255 : 8'(p);
	endfunction

	// Sends one command transaction after a random idle gap.
	task automatic send_cmd(cmd_t c);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	// Stops sending and waits until every predicted response has come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Setup and access phase of one register write; psel is left high for the caller.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// Rewrites every register once the block has gone idle.
	task automatic load_settings(int w, int h, int ox, int oy, int mode, int amul, int sc);
		drain();
		repeat (8) @(posedge clk);
		write_reg(REG_FB_WIDTH, 32'(w));
		write_reg(REG_FB_HEIGHT, 32'(h));
		write_reg(REG_ORIGIN_X, {16'h0, 16'(ox)});
		write_reg(REG_ORIGIN_Y, {16'h0, 16'(oy)});
		write_reg(REG_BLIT_MODE, 32'(mode));
		write_reg(REG_ALPHA_MUL, 32'(amul));
		write_reg(REG_SCALE, 32'(sc));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		cmd_t c;
		int   w;
		int   h;
		int   ew;
		int   eh;
		int   ox;
		int   oy;
		int   mode;
		int   amul;
		int   sc;
		int   step;
		int   roll;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset state: cleared store, full size, plain blend.
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_READ, 32'hFFFFFFFF, 8'd255, 8'd255));
		send_cmd(mk_cmd(CMD_BLIT, 32'h11223300, 8'd3, 8'd3));
		send_cmd(mk_cmd(CMD_BLIT, 32'hAABBCCFF, 8'd255, 8'd255));
		send_cmd(mk_cmd(CMD_BLIT, 32'h80402080, 8'd255, 8'd255));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd255, 8'd255));
		send_cmd(mk_cmd(CMD_CLEAR, 32'h12345678, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd128, 8'd7));
		send_cmd(mk_cmd(CMD_SPARE, 32'hFFFFFFFF, 8'd255, 8'd255));

		// Oversized width, one row, unused mode code behaving as plain blend.
		load_settings(511, 1, -1, 0, MODE_UNUSED, 0, 0);
		send_cmd(mk_cmd(CMD_BLIT, 32'h0000FFFF, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_BLIT, 32'hFFFFFF7F, 8'd1, 8'd0));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd255, 8'd0));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd0, 8'd1));

		// Empty framebuffer: nothing is written and reads give zero.
		load_settings(0, 256, 32767, -32768, MODE_MUL, 255, 31);
		send_cmd(mk_cmd(CMD_CLEAR, 32'hDEADBEEF, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_BLIT, 32'hFFFFFFFF, 8'd0, 8'd0));

		// Alpha multiplier of zero suppresses the write.
		load_settings(20, 12, -3, -2, MODE_MUL, 0, 16);
		send_cmd(mk_cmd(CMD_CLEAR, 32'h01020304, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_BLIT, 32'hFFFFFFFF, 8'd5, 8'd5));

		load_settings(20, 12, -3, -2, MODE_MUL, 128, 16);
		send_cmd(mk_cmd(CMD_BLIT, 32'h20406080, 8'd5, 8'd5));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd2, 8'd3));

		// Saturated scale, block clipped at the top-left corner.
		load_settings(20, 12, -3, -2, MODE_SCALE, 128, 31);
		send_cmd(mk_cmd(CMD_BLIT, 32'hCAFEBABE, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_BLIT, 32'h12345600, 8'd0, 8'd0));
		send_cmd(mk_cmd(CMD_READ, 32'h0, 8'd12, 8'd11));

		// Scale of one falls back to plain blend; scale of zero writes nothing.
		load_settings(20, 12, 0, 0, MODE_SCALE, 255, 1);
		send_cmd(mk_cmd(CMD_BLIT, 32'h55AA5580, 8'd1, 8'd1));
		load_settings(20, 12, 0, 0, MODE_SCALE, 255, 0);
		send_cmd(mk_cmd(CMD_BLIT, 32'h55AA55FF, 8'd1, 8'd1));

		// Random phases, each with its own settings.
		for (int ph = 0; ph < 40; ph++) begin
			w = pick_dim();
			h = pick_dim();
			ew = (w > FB_SIDE_DEF) ? FB_SIDE_DEF : w;
			eh = (h > FB_SIDE_DEF) ? FB_SIDE_DEF : h;
			ox = pick_origin();
			oy = pick_origin();
			mode = $urandom_range(0, 3);
			roll = $urandom_range(0, 3);
			amul = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(1, 254);
			roll = $urandom_range(0, 15);
			if (roll < 10) sc = $urandom_range(1, 4);
			else if (roll < 12) sc = MAX_SCALE_DEF;
			else if (roll == 12) sc = $urandom_range(17, 31);
			else if (roll == 13) sc = 0;
			else sc = $urandom_range(2, 15);
			load_settings(w, h, ox, oy, mode, amul, sc);
			calm_phase = ($urandom_range(0, 4) == 0);
			step = (mode == MODE_SCALE && sc > 1) ? ((sc > MAX_SCALE_DEF) ? MAX_SCALE_DEF : sc) : 1;

			for (int n = 0; n < 40; n++) begin
				c.pixel = $urandom();
				roll = $urandom_range(0, 3);
				if (roll == 0) c.pixel[7:0] = 8'h00;
				else if (roll == 1) c.pixel[7:0] = ALPHA_OPAQUE;
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					// Blits aimed at the visible part of the sprite frame.
					c.command = CMD_BLIT;
					c.pos_x = near_pos((ox < 0) ? -ox / step : 0, ew / step + 1);
					c.pos_y = near_pos((oy < 0) ? -oy / step : 0, eh / step + 1);
				end else if (roll < 88) begin
					c.command = CMD_READ;
					c.pos_x = near_pos(0, ew + 1);
					c.pos_y = near_pos(0, eh + 1);
				end else begin
					// Clears only where the area keeps them short.
					if (roll < 95) c.command = (ew * eh <= 4096) ? CMD_CLEAR : CMD_READ;
					else c.command = CMD_SPARE;
					c.pos_x = 8'($urandom());
					c.pos_y = 8'($urandom());
				end
				send_cmd(c);
				if ($urandom_range(0, 99) == 0) drain();
			end
		end

		// Wait for the last responses, then allow for strays.
		calm_phase = 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("sprite_blit_alpha_blend_top verification clean");
		end else begin
			$display("sprite_blit_alpha_blend_top verification failed");
		end
		$finish;
	end

endmodule
